>>> hw/rtl/arx_iir_filter_defines.svh
// Assertion helpers for the ARX filter. Both sample on clk_i and are
// disabled while rst_ni is low.
`ifndef ARX_IIR_FILTER_DEFINES_SVH
`define ARX_IIR_FILTER_DEFINES_SVH

// Same-cycle implication.
`define ARXF_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ARXF_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/arxf_pkg.sv
`timescale 1ns / 1ps

package arxf_pkg;

  // Fixed register and field widths
  localparam int COEF_W     = 16;
  localparam int DELAY_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  // Coefficient registers per polynomial
  localparam int COEF_REGS  = 3;

  // Defaults for the top-level parameters
  localparam int DEF_NUM_A_TAPS     = 3;
  localparam int DEF_NUM_B_TAPS     = 3;
  localparam int DEF_MAX_DELAY      = 8;
  localparam int DEF_SAMPLE_WIDTH   = 16;
  localparam int DEF_COEF_FRAC_BITS = 14;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELAY  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_A_1    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_A_2    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_A_3    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_B_0    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_B_1    = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_B_2    = CFG_IDX_W'(6);

  // History control shared by every cell in a row
  typedef struct packed {
    logic shift;
    logic clear;
  } hist_ctrl_t;

  // Input tap control: history plus product capture
  typedef struct packed {
    hist_ctrl_t hist;
    logic       load;
  } tap_ctrl_t;

endpackage

>>> hw/rtl/arx_iir_filter.sv
// Path: tap row, product registers, delay-line head, then the output register.
// Throughput: one sample per cycle unless the output stalls; the loop that sets it is
//   the feedback row (NUM_A_TAPS multipliers, accumulate, round, saturate).
// Reset: coefficients, delay and every history row clear to zero at once; no
//   clearing pass. A write to a listed register also clears every history row.
`timescale 1ns / 1ps

`include "arx_iir_filter_defines.svh"

module arx_iir_filter #(
  parameter int NUM_A_TAPS     = arxf_pkg::DEF_NUM_A_TAPS,
  parameter int NUM_B_TAPS     = arxf_pkg::DEF_NUM_B_TAPS,
  parameter int MAX_DELAY      = arxf_pkg::DEF_MAX_DELAY,
  parameter int SAMPLE_WIDTH   = arxf_pkg::DEF_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = arxf_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Sample input
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [SAMPLE_WIDTH-1:0] input_sample, zero fill up to the byte boundary
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  // Sample output
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [SAMPLE_WIDTH-1:0] output_sample, zero fill up to the byte boundary
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
  // Configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [arxf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [arxf_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import arxf_pkg::*;

  localparam int DATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int PROD_W  = SAMPLE_WIDTH + COEF_W;
  // Sum of the input taps
  localparam int V_W     = PROD_W + $clog2(NUM_B_TAPS);
  localparam int ACC_RAW = PROD_W + $clog2(NUM_A_TAPS + NUM_B_TAPS) + 1;
  localparam int ACC_W   = (ACC_RAW > COEF_FRAC_BITS + 2) ? ACC_RAW : COEF_FRAC_BITS + 2;
  // Delay line holds the current tap sum plus MAX_DELAY older ones
  localparam int VDEPTH  = MAX_DELAY + 1;
  localparam int DIDX_W  = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers. The port never stalls; a write to a listed
  // index also clears every history cell.
  // ---------------------------------------------------------------------------
  logic                     cfg_hit;
  logic [DELAY_W-1:0]       delay_q;
  logic signed [COEF_W-1:0] a_coef_q [COEF_REGS];
  logic signed [COEF_W-1:0] b_coef_q [COEF_REGS];

  assign cfg_ready_o = 1'b1;

  always_comb begin
    unique case (cfg_index_i) inside
      REG_DELAY, REG_A_1, REG_A_2, REG_A_3, REG_B_0, REG_B_1, REG_B_2: begin
        cfg_hit = cfg_valid_i;
      end
      default: begin
        cfg_hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= '0;
      for (int i = 0; i < COEF_REGS; i++) begin
        a_coef_q[i] <= '0;
        b_coef_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DELAY: delay_q     <= cfg_data_i[DELAY_W-1:0];
        REG_A_1:   a_coef_q[0] <= cfg_data_i;
        REG_A_2:   a_coef_q[1] <= cfg_data_i;
        REG_A_3:   a_coef_q[2] <= cfg_data_i;
        REG_B_0:   b_coef_q[0] <= cfg_data_i;
        REG_B_1:   b_coef_q[1] <= cfg_data_i;
        REG_B_2:   b_coef_q[2] <= cfg_data_i;
        default: begin
          // unlisted index: drop the write
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow. Four slots: tap row loaded (s1), products registered (s2),
  // tap sum at the head of the delay line (s3), output register. A slot
  // advances when the next one is empty or advancing too, so a held result
  // only blocks intake once every slot behind it is full.
  // ---------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic mv1, mv2, mv3;
  logic in_xfer;

  assign mv3           = s3_v_q && (!out_v_q || m_axis_tready);
  assign mv2           = s2_v_q && (!s3_v_q || mv3);
  assign mv1           = s1_v_q && (!s2_v_q || mv2);
  assign s_axis_tready = !s1_v_q || mv1;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_v_q <= 1'b1;
      end else if (mv1) begin
        s1_v_q <= 1'b0;
      end
      if (mv1) begin
        s2_v_q <= 1'b1;
      end else if (mv2) begin
        s2_v_q <= 1'b0;
      end
      if (mv2) begin
        s3_v_q <= 1'b1;
      end else if (mv3) begin
        s3_v_q <= 1'b0;
      end
      if (mv3) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input tap row: cell i holds the input i samples back. Products are taken
  // from the newest NUM_B_TAPS samples; the delay is applied afterwards to
  // their sum, which gives the same value as delaying each tap.
  // ---------------------------------------------------------------------------
  tap_ctrl_t                b_ctrl;
  logic signed [SAMPLE_WIDTH-1:0] x_row  [NUM_B_TAPS];
  logic signed [PROD_W-1:0]       b_prod [NUM_B_TAPS];
  logic signed [V_W-1:0]          v_sum;

  assign b_ctrl.hist.shift = in_xfer;
  assign b_ctrl.hist.clear = cfg_hit;
  assign b_ctrl.load       = mv1;

  for (genvar i = 0; i < NUM_B_TAPS; i++) begin : g_b_row
    logic signed [SAMPLE_WIDTH-1:0] cell_in;
    logic signed [COEF_W-1:0]       cell_coef;

    if (i == 0) begin : g_head
      assign cell_in = s_axis_tdata[SAMPLE_WIDTH-1:0];
    end else begin : g_link
      assign cell_in = x_row[i-1];
    end

    // taps past the register set weigh zero
    if (i < COEF_REGS) begin : g_coef
      assign cell_coef = b_coef_q[i];
    end else begin : g_zero
      assign cell_coef = '0;
    end

    arxf_b_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (b_ctrl),
      .sample_i (cell_in),
      .coef_i   (cell_coef),
      .sample_o (x_row[i]),
      .prod_o   (b_prod[i])
    );
  end

  always_comb begin
    v_sum = '0;
    for (int i = 0; i < NUM_B_TAPS; i++) begin
      v_sum = v_sum + V_W'(b_prod[i]);
    end
  end

  // ---------------------------------------------------------------------------
  // Delay line of tap sums: entry 0 is the newest. Read at the saturated
  // delay setting.
  // ---------------------------------------------------------------------------
  hist_ctrl_t               v_ctrl;
  logic signed [V_W-1:0]    v_row [VDEPTH];
  logic [DIDX_W-1:0]        d_sel;

  assign v_ctrl.shift = mv2;
  assign v_ctrl.clear = cfg_hit;

  for (genvar i = 0; i < VDEPTH; i++) begin : g_v_row
    logic signed [V_W-1:0] cell_in;

    if (i == 0) begin : g_head
      assign cell_in = v_sum;
    end else begin : g_link
      assign cell_in = v_row[i-1];
    end

    arxf_dly_cell #(
      .WIDTH (V_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (v_ctrl),
      .data_i (cell_in),
      .data_o (v_row[i])
    );
  end

  assign d_sel = (32'(delay_q) > 32'(MAX_DELAY)) ? DIDX_W'(MAX_DELAY) : DIDX_W'(delay_q);

  // ---------------------------------------------------------------------------
  // Feedback row: cell j holds the output j+1 samples back. The delayed tap
  // sum minus the weighted past outputs is rounded half up, floored and
  // saturated, then shifts into the row and the output register together.
  // ---------------------------------------------------------------------------
  hist_ctrl_t                     a_ctrl;
  logic signed [SAMPLE_WIDTH-1:0] y_row  [NUM_A_TAPS];
  logic signed [PROD_W-1:0]       a_prod [NUM_A_TAPS];
  logic signed [ACC_W-1:0]        a_sum;
  logic signed [ACC_W-1:0]        acc;
  logic signed [ACC_W-1:0]        y_full;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic [ACC_W-SAMPLE_WIDTH:0]    y_top;
  logic [SAMPLE_WIDTH-1:0]        out_data_q;

  assign a_ctrl.shift = mv3;
  assign a_ctrl.clear = cfg_hit;

  for (genvar j = 0; j < NUM_A_TAPS; j++) begin : g_a_row
    logic signed [SAMPLE_WIDTH-1:0] cell_in;
    logic signed [COEF_W-1:0]       cell_coef;

    if (j == 0) begin : g_head
      assign cell_in = y_sat;
    end else begin : g_link
      assign cell_in = y_row[j-1];
    end

    if (j < COEF_REGS) begin : g_coef
      assign cell_coef = a_coef_q[j];
    end else begin : g_zero
      assign cell_coef = '0;
    end

    arxf_a_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (a_ctrl),
      .sample_i (cell_in),
      .coef_i   (cell_coef),
      .sample_o (y_row[j]),
      .prod_o   (a_prod[j])
    );
  end

  always_comb begin
    a_sum = '0;
    for (int j = 0; j < NUM_A_TAPS; j++) begin
      a_sum = a_sum + ACC_W'(a_prod[j]);
    end
  end

  assign acc    = ACC_W'(v_row[d_sel]) - a_sum + (ACC_W'(1) << (COEF_FRAC_BITS - 1));
  assign y_full = acc >>> COEF_FRAC_BITS;
  assign y_top  = y_full[ACC_W-1:SAMPLE_WIDTH-1];

  // Out of range when the bits above the sample are not a plain sign copy
  always_comb begin
    if ((y_top == '0) || (y_top == '1)) begin
      y_sat = y_full[SAMPLE_WIDTH-1:0];
    end else if (y_full[ACC_W-1]) begin
      y_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  // Hold the result until the output transfer
  always_ff @(posedge clk_i) begin
    if (mv3) begin
      out_data_q <= y_sat;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = DATA_W'(out_data_q);

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `ARXF_ASSERT_NXT(a_cfg_clears_feedback, cfg_hit, (y_row[0] == '0), "history kept after write")
  `ARXF_ASSERT_NXT(a_feedback_holds_on_stall, (s3_v_q && out_v_q && !m_axis_tready && !cfg_hit), $stable(y_row[0]), "feedback moved while output stalled")
  `ARXF_ASSERT_IMP(a_result_has_source, $rose(out_v_q), $past(s3_v_q), "result without a sample behind it")

endmodule

>>> hw/rtl/arxf_b_cell.sv
`timescale 1ns / 1ps

// Input tap: hold one past input sample, pass it on, register its product.
module arxf_b_cell #(
  parameter int SAMPLE_WIDTH = arxf_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  arxf_pkg::tap_ctrl_t                             ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0]                  sample_i,
  input  logic signed [arxf_pkg::COEF_W-1:0]              coef_i,
  output logic signed [SAMPLE_WIDTH-1:0]                  sample_o,
  output logic signed [SAMPLE_WIDTH+arxf_pkg::COEF_W-1:0] prod_o
);
  import arxf_pkg::*;

  localparam int PROD_W = SAMPLE_WIDTH + COEF_W;

  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic signed [PROD_W-1:0]       prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (ctrl_i.hist.clear) begin
      sample_q <= '0;
    end else if (ctrl_i.hist.shift) begin
      sample_q <= sample_i;
    end
  end

  // Capture uses the sample before any shift on the same edge
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      prod_q <= sample_q * coef_i;
    end
  end

  assign sample_o = sample_q;
  assign prod_o   = prod_q;

endmodule

>>> hw/rtl/arxf_dly_cell.sv
`timescale 1ns / 1ps

// One step of the delay line for the summed input taps.
module arxf_dly_cell #(
  parameter int WIDTH = arxf_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  arxf_pkg::hist_ctrl_t     ctrl_i,
  input  logic signed [WIDTH-1:0]  data_i,
  output logic signed [WIDTH-1:0]  data_o
);
  import arxf_pkg::*;

  logic signed [WIDTH-1:0] data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (ctrl_i.clear) begin
      data_q <= '0;
    end else if (ctrl_i.shift) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

>>> hw/rtl/arxf_a_cell.sv
`timescale 1ns / 1ps

// Feedback tap: hold one past output, pass it on, weight it.
module arxf_a_cell #(
  parameter int SAMPLE_WIDTH = arxf_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  arxf_pkg::hist_ctrl_t                            ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0]                  sample_i,
  input  logic signed [arxf_pkg::COEF_W-1:0]              coef_i,
  output logic signed [SAMPLE_WIDTH-1:0]                  sample_o,
  output logic signed [SAMPLE_WIDTH+arxf_pkg::COEF_W-1:0] prod_o
);
  import arxf_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (ctrl_i.clear) begin
      sample_q <= '0;
    end else if (ctrl_i.shift) begin
      sample_q <= sample_i;
    end
  end

  assign sample_o = sample_q;
  assign prod_o   = sample_q * coef_i;

endmodule
